// ===== hw/rtl/tce_pkg.sv =====
package tce_pkg;

    localparam int NumPix    = 8;
    localparam int NumColors = 16;
    localparam int ColorW    = 4;
    localparam int CntW      = $clog2(NumPix + 1);
    localparam int KeyW      = CntW + ColorW;
    localparam int TreeLvls  = $clog2(NumColors);

    typedef logic [ColorW-1:0]                 t_color;
    typedef logic [CntW-1:0]                   t_cnt;
    typedef logic [KeyW-1:0]                   t_key;
    typedef logic [NumPix-1:0][ColorW-1:0]     t_pix_vec;
    typedef logic [NumColors-1:0][CntW-1:0]    t_cnt_vec;
    typedef logic [NumColors-1:0][KeyW-1:0]    t_key_vec;

    // balanced max tree; keys carry the index so no two are equal
    function automatic t_key max_key(t_key_vec keys);
        t_key_vec w;
        w = keys;
        for (int lvl = 0; lvl < TreeLvls; lvl++) begin
            for (int j = 0; j < NumColors / 2; j++) begin
                if (j < (NumColors >> (lvl + 1))) begin
                    w[j] = (w[2*j] >= w[2*j+1]) ? w[2*j] : w[2*j+1];
                end
            end
        end
        return w[0];
    endfunction

endpackage

// ===== hw/rtl/tce_hist.sv =====
module tce_hist (
    input  tce_pkg::t_pix_vec i_pix,
    output tce_pkg::t_cnt_vec o_counts
);

    // one small popcount per color
    always_comb begin
        for (int c = 0; c < tce_pkg::NumColors; c++) begin
            o_counts[c] = '0;
            for (int i = 0; i < tce_pkg::NumPix; i++) begin
                if (i_pix[i] == tce_pkg::ColorW'(c)) begin
                    o_counts[c] = o_counts[c] + tce_pkg::CntW'(1);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/two_color_attribute_cell_encoder.sv =====
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_pix0 .. i_pix7 (4 bits each)
// out       output     o_out_valid / i_out_ready   o_pattern, o_ink_color, o_paper_color
//
// one cell per cycle sustained while the output is not stalled
// four register ranks: input, color counts, ink choice, result
// synchronous active-low reset clears the valid bits only
// a stall on the output backs up stage by stage; bubbles are squeezed out
module two_color_attribute_cell_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_pix0,
    input  logic [3:0] i_pix1,
    input  logic [3:0] i_pix2,
    input  logic [3:0] i_pix3,
    input  logic [3:0] i_pix4,
    input  logic [3:0] i_pix5,
    input  logic [3:0] i_pix6,
    input  logic [3:0] i_pix7,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pattern,
    output logic [3:0] o_ink_color,
    output logic [3:0] o_paper_color
);

    logic                       r_s1_valid;
    tce_pkg::t_pix_vec          r_s1_pix;
    logic                       r_s2_valid;
    tce_pkg::t_pix_vec          r_s2_pix;
    tce_pkg::t_cnt_vec          r_s2_cnt;
    logic                       r_s3_valid;
    tce_pkg::t_pix_vec          r_s3_pix;
    tce_pkg::t_cnt_vec          r_s3_cnt;
    tce_pkg::t_color            r_s3_ink;
    logic                       r_out_valid;
    logic [tce_pkg::NumPix-1:0] r_pattern;
    tce_pkg::t_color            r_ink;
    tce_pkg::t_color            r_paper;

    logic                       s1_ld, s2_ld, s3_ld, out_ld;
    tce_pkg::t_pix_vec          in_pix;
    tce_pkg::t_cnt_vec          cnt;
    tce_pkg::t_key_vec          ink_keys, paper_keys;
    tce_pkg::t_key              ink_best, paper_best;
    tce_pkg::t_color            n_s3_ink;
    tce_pkg::t_color            n_paper;
    logic [tce_pkg::NumPix-1:0] n_pattern;

    assign in_pix = {i_pix7, i_pix6, i_pix5, i_pix4, i_pix3, i_pix2, i_pix1, i_pix0};

    assign out_ld = !r_out_valid || i_out_ready;
    assign s3_ld  = !r_s3_valid || out_ld;
    assign s2_ld  = !r_s2_valid || s3_ld;
    assign s1_ld  = !r_s1_valid || s2_ld;
    assign o_in_ready = s1_ld;

    tce_hist u_hist (
        .i_pix    (r_s1_pix),
        .o_counts (cnt)
    );

    // ink: highest count among non-zero colors, higher index wins a tie
    always_comb begin
        for (int c = 0; c < tce_pkg::NumColors; c++) begin
            ink_keys[c] = {(c == 0) ? tce_pkg::t_cnt'(0) : r_s2_cnt[c], tce_pkg::ColorW'(c)};
        end
        ink_best = tce_pkg::max_key(ink_keys);
        if (ink_best[tce_pkg::KeyW-1 -: tce_pkg::CntW] == '0) begin
            n_s3_ink = '0;
        end else begin
            n_s3_ink = ink_best[tce_pkg::ColorW-1:0];
        end
    end

    // paper: highest count among the rest, lower index wins a tie (inverted index)
    always_comb begin
        for (int c = 0; c < tce_pkg::NumColors; c++) begin
            paper_keys[c] = {(r_s3_ink == tce_pkg::ColorW'(c)) ? tce_pkg::t_cnt'(0) : r_s3_cnt[c],
                             ~tce_pkg::ColorW'(c)};
        end
        paper_best = tce_pkg::max_key(paper_keys);
        if (r_s3_ink == '0 || paper_best[tce_pkg::KeyW-1 -: tce_pkg::CntW] == '0) begin
            n_paper = '0;
        end else begin
            n_paper = ~paper_best[tce_pkg::ColorW-1:0];
        end
        for (int i = 0; i < tce_pkg::NumPix; i++) begin
            n_pattern[tce_pkg::NumPix-1-i] = (r_s3_ink != '0) && (r_s3_pix[i] != n_paper);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ld)  r_s1_valid  <= i_in_valid;
            if (s2_ld)  r_s2_valid  <= r_s1_valid;
            if (s3_ld)  r_s3_valid  <= r_s2_valid;
            if (out_ld) r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ld && i_in_valid) begin
            r_s1_pix <= in_pix;
        end
        if (s2_ld && r_s1_valid) begin
            r_s2_pix <= r_s1_pix;
            r_s2_cnt <= cnt;
        end
        if (s3_ld && r_s2_valid) begin
            r_s3_pix <= r_s2_pix;
            r_s3_cnt <= r_s2_cnt;
            r_s3_ink <= n_s3_ink;
        end
        if (out_ld && r_s3_valid) begin
            r_pattern <= n_pattern;
            r_ink     <= r_s3_ink;
            r_paper   <= n_paper;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pattern     = r_pattern;
    assign o_ink_color   = r_ink;
    assign o_paper_color = r_paper;

endmodule

// ===== hw/rtl/tce_checker.sv =====
module tce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_pattern,
    input logic [3:0] o_ink_color,
    input logic [3:0] o_paper_color
);

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pattern)
            && $stable(o_ink_color) && $stable(o_paper_color))
        else $error("stalled result changed");

    // a blank cell carries no pattern and no paper
    a_zero_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ink_color == 4'd0 |-> o_pattern == 8'd0 && o_paper_color == 4'd0)
        else $error("zero ink with pattern or paper");

    a_paper_ne_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ink_color != 4'd0 |-> o_paper_color != o_ink_color)
        else $error("paper equals ink");

    // with ink present at least one pixel is ink
    a_ink_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ink_color != 4'd0 |-> o_pattern != 8'd0)
        else $error("ink chosen but no ink pixel");

endmodule

bind two_color_attribute_cell_encoder tce_checker u_tce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pattern     (o_pattern),
    .o_ink_color   (o_ink_color),
    .o_paper_color (o_paper_color)
);

// ===== tb/tb_two_color_attribute_cell_encoder.sv =====
module tb_two_color_attribute_cell_encoder;

    localparam int IdlePct   = 26;
    localparam int StallMax  = 1000;
    localparam int TailWait  = 10;
    localparam int MaxShown  = 10;

    typedef struct packed {
        logic [7:0]      pattern;
        tce_pkg::t_color ink;
        tce_pkg::t_color paper;
    } t_cell_attr;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [3:0] i_pix0        = '0;
    logic [3:0] i_pix1        = '0;
    logic [3:0] i_pix2        = '0;
    logic [3:0] i_pix3        = '0;
    logic [3:0] i_pix4        = '0;
    logic [3:0] i_pix5        = '0;
    logic [3:0] i_pix6        = '0;
    logic [3:0] i_pix7        = '0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic [7:0] o_pattern;
    logic [3:0] o_ink_color;
    logic [3:0] o_paper_color;

    t_cell_attr attrs_due[$];
    int         n_mismatch   = 0;
    int         quiet_cycles = 0;
    bit         full_rate    = 1'b0;

    two_color_attribute_cell_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pix0       (i_pix0),
        .i_pix1       (i_pix1),
        .i_pix2       (i_pix2),
        .i_pix3       (i_pix3),
        .i_pix4       (i_pix4),
        .i_pix5       (i_pix5),
        .i_pix6       (i_pix6),
        .i_pix7       (i_pix7),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pattern    (o_pattern),
        .o_ink_color  (o_ink_color),
        .o_paper_color(o_paper_color)
    );

    always #4 i_clk = ~i_clk;

    // ink: most frequent non-zero color, highest index on a tie
    // paper: most frequent of the rest, lowest index on a tie
    function automatic t_cell_attr quantize_cell(tce_pkg::t_pix_vec px);
        int         hist [tce_pkg::NumColors];
        int         ink_cnt;
        int         paper_cnt;
        t_cell_attr res;
        for (int c = 0; c < tce_pkg::NumColors; c++) begin
            hist[c] = 0;
        end
        for (int p = 0; p < tce_pkg::NumPix; p++) begin
            hist[px[p]]++;
        end
        res       = '0;
        ink_cnt   = 0;
        paper_cnt = 0;
        for (int c = 1; c < tce_pkg::NumColors; c++) begin
            if (hist[c] != 0 && hist[c] >= ink_cnt) begin
                res.ink = tce_pkg::t_color'(c);
                ink_cnt = hist[c];
            end
        end
        if (res.ink != '0) begin
            for (int c = 0; c < tce_pkg::NumColors; c++) begin
                if (tce_pkg::t_color'(c) != res.ink && hist[c] > paper_cnt) begin
                    res.paper = tce_pkg::t_color'(c);
                    paper_cnt = hist[c];
                end
            end
            // anything that is not paper gets drawn as ink
            for (int p = 0; p < tce_pkg::NumPix; p++) begin
                if (px[p] != res.paper) begin
                    res.pattern[tce_pkg::NumPix-1-p] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic tce_pkg::t_pix_vec random_cell();
        tce_pkg::t_color   palette [4];
        int                kinds;
        int                mode;
        tce_pkg::t_pix_vec px;
        mode  = $urandom_range(9);
        kinds = $urandom_range(4, 1);
        for (int k = 0; k < 4; k++) begin
            palette[k] = tce_pkg::t_color'($urandom_range(tce_pkg::NumColors-1));
        end
        if (mode < 3) begin
            palette[0] = '0;
        end
        for (int p = 0; p < tce_pkg::NumPix; p++) begin
            if (mode == 9) begin
                px[p] = tce_pkg::t_color'($urandom_range(tce_pkg::NumColors-1));
            end else begin
                px[p] = palette[$urandom_range(kinds-1)];
            end
        end
        return px;
    endfunction

    task automatic send_cell(input tce_pkg::t_pix_vec px);
        while (!full_rate && $urandom_range(99) < IdlePct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pix0     <= px[0];
        i_pix1     <= px[1];
        i_pix2     <= px[2];
        i_pix3     <= px[3];
        i_pix4     <= px[4];
        i_pix5     <= px[5];
        i_pix6     <= px[6];
        i_pix7     <= px[7];
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        attrs_due.push_back(quantize_cell(px));
    endtask

    task automatic wait_drained();
        while (attrs_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_corner_cells();
        tce_pkg::t_pix_vec cells [$];
        cells.push_back({8{4'h0}});                                 // all zero
        cells.push_back({8{4'hF}});                                 // all max
        cells.push_back({8{4'h5}});                                 // single color
        cells.push_back({4'h0, 4'h0, 4'h0, 4'h6, 4'h0, 4'h0, 4'h0, 4'h0}); // lone ink in zeros
        cells.push_back({4'h0, 4'h3, 4'h0, 4'h3, 4'h0, 4'h3, 4'h0, 4'h3}); // zero as paper
        cells.push_back({4'h9, 4'h3, 4'h9, 4'h3, 4'h9, 4'h3, 4'h9, 4'h3}); // ink tie
        cells.push_back({4'h4, 4'h4, 4'h7, 4'h4, 4'h2, 4'h4, 4'h7, 4'h2}); // paper tie
        cells.push_back({4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8}); // all distinct
        cells.push_back({4'h7, 4'h6, 4'h5, 4'h4, 4'h3, 4'h2, 4'h1, 4'h0}); // distinct with zero
        cells.push_back({4'h1, 4'h1, 4'h1, 4'h2, 4'h2, 4'h3, 4'h0, 4'h0}); // stray colors to ink
        cells.push_back({4'hA, 4'h5, 4'hA, 4'h5, 4'hA, 4'h5, 4'hA, 4'h5});
        cells.push_back({4'h5, 4'hA, 4'h5, 4'hA, 4'h5, 4'hA, 4'h5, 4'hA});
        cells.push_back({4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0});
        cells.push_back({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1});
        cells.push_back({4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'hE}); // paper beats zero absent
        foreach (cells[n]) begin
            send_cell(cells[n]);
        end
    endtask

    task automatic test_random_cells(input int count);
        for (int n = 0; n < count; n++) begin
            send_cell(random_cell());
        end
    endtask

    task automatic test_back_to_back(input int count);
        full_rate = 1'b1;
        test_random_cells(count);
        full_rate = 1'b0;
    endtask

    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        if (n_mismatch < MaxShown) begin
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
        end
        n_mismatch++;
    endtask

    // output side: random stalls and result check on each transfer
    always @(posedge i_clk) begin
        t_cell_attr want;
        i_out_ready <= full_rate || ($urandom_range(99) >= IdlePct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (attrs_due.size() == 0) begin
                note_mismatch("unexpected transfer, pattern", 0, o_pattern);
            end else begin
                want = attrs_due.pop_front();
                if (o_pattern !== want.pattern) begin
                    note_mismatch("pattern", want.pattern, o_pattern);
                end
                if (o_ink_color !== want.ink) begin
                    note_mismatch("ink_color", want.ink, o_ink_color);
                end
                if (o_paper_color !== want.paper) begin
                    note_mismatch("paper_color", want.paper, o_paper_color);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallMax) begin
            $display("tb_two_color_attribute_cell_encoder failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cells();
        test_random_cells(250);
        test_drain_pause();
        test_back_to_back(150);
        test_random_cells(250);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (TailWait) @(posedge i_clk);
        if (n_mismatch == 0 && attrs_due.size() == 0) begin
            $display("tb_two_color_attribute_cell_encoder passed");
        end else begin
            $display("tb_two_color_attribute_cell_encoder failed");
        end
        $finish;
    end

endmodule
